// ===== rtl/core/pes_pkg.sv =====
package pes_pkg;

  // width of each position or velocity field on the stream ports
  localparam int FIELD_BITS = 32;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS = 31;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_SPEED = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PANIC_DIST = 8'd1;

  // steering opcodes
  typedef enum logic [1:0] {
    OP_SEEK   = 2'd0,
    OP_FLEE   = 2'd1,
    OP_PURSUE = 2'd2,
    OP_EVADE  = 2'd3
  } opcode_t;

  // operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    UOP_MULQ = 2'd0,
    UOP_MULR = 2'd1,
    UOP_SQRT = 2'd2,
    UOP_DIV  = 2'd3
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_P_HEAD,
    ST_P_M1,
    ST_P_M2,
    ST_P_M3,
    ST_P_M4,
    ST_P_DEC,
    ST_PR_D,
    ST_PR_T,
    ST_PR_DIV,
    ST_PR_MX,
    ST_PR_MY,
    ST_SEEK,
    ST_FLEE,
    ST_F_CHK,
    ST_FX,
    ST_FY,
    ST_FIN,
    ST_N_ABS,
    ST_N_SH,
    ST_N_SQX,
    ST_N_SQY,
    ST_N_SQRT,
    ST_N_DX,
    ST_N_DY
  } state_t;

endpackage

// ===== rtl/core/pursuit_evasion_steering.sv =====
// Steering force for one agent: seek, flee, pursue and evade on signed fixed-point
// positions and velocities (WORD_BITS wide, FRAC_BITS fraction bits), with an optional
// running sum that is emitted on the item marked tlast. One item is worked at a time;
// s_axis_tready is high only while the block is idle. All arithmetic runs on one shared
// bit-serial unit (one multiplier bit, one root bit or one quotient bit per clock); a vector
// normalization uses it for two squares, a square root and, for a nonzero length, two
// divisions. A finished result waits in an output register, so the next item is taken
// while it is still pending. Configuration writes are accepted at any time and must
// only be issued while the block is idle.
module pursuit_evasion_steering #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // self_pos_x, self_pos_y, self_vel_x, self_vel_y,
  // target_pos_x, target_pos_y, target_vel_x, target_vel_y
  input  logic [8*pes_pkg::FIELD_BITS-1:0]    s_axis_tdata,
  // opcode, sum_mode
  input  logic [2:0]                          s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // force_x, force_y
  output logic [2*pes_pkg::FIELD_BITS-1:0]    m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pes_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pes_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import pes_pkg::*;

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int LW = W + 2;
  localparam int SW = (W + 2 > 33) ? W + 2 : 33;
  localparam int SHW = $clog2(W + 2);
  localparam logic signed [SW-1:0] WMAX_S = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] WMIN_S = ~WMAX_S;
  localparam logic [63:0] WMAX_U = (64'd1 << (W - 1)) - 64'd1;
  localparam logic [63:0] MS_RESET_U = (64'd65536 > WMAX_U) ? WMAX_U : 64'd65536;
  localparam logic [63:0] HEAD_THR_U = (64'd95 << F) / 64'd100;
  localparam logic signed [W+1:0] HEAD_THR = (W+2)'(HEAD_THR_U);

  function automatic logic signed [W-1:0] satw(input logic signed [SW-1:0] v);
    if (v > WMAX_S) return WMAX_S[W-1:0];
    if (v < WMIN_S) return WMIN_S[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic signed [SW-1:0] xs(input logic signed [W:0] v);
    return {{(SW-W-1){v[W]}}, v};
  endfunction

  function automatic logic signed [W:0] wx1(input logic signed [W-1:0] v);
    return {v[W-1], v};
  endfunction

  function automatic logic signed [W+1:0] wx2(input logic signed [W-1:0] v);
    return {{2{v[W-1]}}, v};
  endfunction

  function automatic logic [31:0] to32(input logic signed [W-1:0] v);
    logic [63:0] e;
    e = {{(64-W){v[W-1]}}, v};
    return e[31:0];
  endfunction

  function automatic logic signed [W-1:0] field_in(input logic [31:0] f);
    return satw({{(SW-32){f[31]}}, f});
  endfunction

  state_t state;
  state_t state_next;
  state_t ret;
  logic   issued;
  logic   issued_next;
  logic   fire;

  // configuration
  logic [W-2:0]             max_speed;
  logic [CFG_DATA_BITS-1:0] panic_dist;

  // captured item
  opcode_t            op;
  logic               sum_mode;
  logic               last;
  logic signed [W-1:0] spx, spy, svx, svy, tpx, tpy, tvx, tvy;

  // working registers
  logic signed [W:0]   nvx, nvy;
  logic [W:0]          ax, ay;
  logic                sgx, sgy;
  logic [SHW-1:0]      sh;
  logic [63:0]         sq;
  logic [31:0]         r;
  logic signed [W-1:0] nux, nuy;
  logic [LW-1:0]       nlen;
  logic [LW-1:0]       tgt_dist;
  logic [W-2:0]        t;
  logic signed [W-1:0] hx, hy, m1, m2, m3, m4;
  logic signed [W-1:0] px, py, fx, fy;
  logic signed [W-1:0] sum_x, sum_y;
  logic                out_valid;
  logic [31:0]         out_x, out_y;

  // shared unit port
  unit_req_t              u_req;
  logic signed [W+1:0]    u_opa, u_opb;
  logic [63:0]            u_rad;
  logic [LW-1:0]          u_num;
  logic [LW:0]            u_den;
  logic                   u_done;
  logic signed [W-1:0]    u_mul_q;
  logic [2*W+1:0]         u_mul_raw;
  logic [31:0]            u_root;
  logic [W-2:0]           u_quo;

  // derived values
  logic signed [W:0]   dx, dy;
  logic signed [W:0]   dot_a, dot_b;
  logic                head_on;
  logic [LW:0]         den;
  logic                outside;
  logic                emit;
  logic                out_free;
  logic                in_acc;
  logic signed [W-1:0] sum_nx, sum_ny;
  logic signed [W-1:0] qs;
  logic                big;

  pes_unit #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_unit (
    .clk     (clk),
    .rst     (rst),
    .req     (u_req),
    .opa     (u_opa),
    .opb     (u_opb),
    .rad     (u_rad),
    .num     (u_num),
    .den     (u_den),
    .done    (u_done),
    .mul_q   (u_mul_q),
    .mul_raw (u_mul_raw),
    .root    (u_root),
    .quo     (u_quo)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {out_y, out_x};

  assign fire = issued && u_done;
  assign dx = wx1(tpx) - wx1(spx);
  assign dy = wx1(tpy) - wx1(spy);
  assign dot_a = wx1(m1) + wx1(m2);
  assign dot_b = wx1(m3) + wx1(m4);
  // target ahead (positive dot) and headings nearly opposed
  assign head_on = !dot_a[W] && (dot_a != '0) &&
                   ($signed({dot_b[W], dot_b}) < -HEAD_THR);
  assign den = (LW+1)'(max_speed) + (LW+1)'(nlen);
  assign outside = 64'(nlen) >= 64'(panic_dist);
  assign emit = !sum_mode || last;
  assign out_free = !out_valid || m_axis_tready;
  assign sum_nx = satw(xs(wx1(sum_x) + wx1(fx)));
  assign sum_ny = satw(xs(wx1(sum_y) + wx1(fy)));
  assign qs = signed'({1'b0, u_quo});
  assign big = |((ax | ay) >> 30);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      issued <= issued_next;
    end
  end

  // sequencer next state and unit requests
  always_comb begin
    state_next = state;
    u_req.start = 1'b0;
    u_req.op = UOP_MULQ;
    u_opa = '0;
    u_opb = '0;
    u_rad = sq;
    u_num = tgt_dist;
    u_den = den;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (op)
          OP_SEEK:   state_next = ST_SEEK;
          OP_FLEE:   state_next = ST_FLEE;
          OP_PURSUE: state_next = ST_N_ABS;
          default:   state_next = ST_PR_D;
        endcase
      end
      ST_P_HEAD: state_next = ST_N_ABS;
      ST_P_M1: begin
        u_opa = {dx[W], dx};
        u_opb = wx2(hx);
        u_req.start = !issued;
        if (fire) state_next = ST_P_M2;
      end
      ST_P_M2: begin
        u_opa = {dy[W], dy};
        u_opb = wx2(hy);
        u_req.start = !issued;
        if (fire) state_next = ST_P_M3;
      end
      ST_P_M3: begin
        u_opa = wx2(hx);
        u_opb = wx2(nux);
        u_req.start = !issued;
        if (fire) state_next = ST_P_M4;
      end
      ST_P_M4: begin
        u_opa = wx2(hy);
        u_opb = wx2(nuy);
        u_req.start = !issued;
        if (fire) state_next = ST_P_DEC;
      end
      ST_P_DEC: state_next = head_on ? ST_SEEK : ST_PR_D;
      ST_PR_D: state_next = ST_N_ABS;
      ST_PR_T: state_next = ST_N_ABS;
      ST_PR_DIV: begin
        u_req.op = UOP_DIV;
        if (den == '0) begin
          state_next = ST_PR_MX;
        end else begin
          u_req.start = !issued;
          if (fire) state_next = ST_PR_MX;
        end
      end
      ST_PR_MX: begin
        u_opa = {3'b000, t};
        u_opb = wx2(tvx);
        u_req.start = !issued;
        if (fire) state_next = ST_PR_MY;
      end
      ST_PR_MY: begin
        u_opa = {3'b000, t};
        u_opb = wx2(tvy);
        u_req.start = !issued;
        if (fire) state_next = (op == OP_PURSUE) ? ST_SEEK : ST_FLEE;
      end
      ST_SEEK: state_next = ST_N_ABS;
      ST_FLEE: state_next = ST_N_ABS;
      ST_F_CHK: state_next = outside ? ST_FIN : ST_FX;
      ST_FX: begin
        u_opa = wx2(nux);
        u_opb = {3'b000, max_speed};
        u_req.start = !issued;
        if (fire) state_next = ST_FY;
      end
      ST_FY: begin
        u_opa = wx2(nuy);
        u_opb = {3'b000, max_speed};
        u_req.start = !issued;
        if (fire) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!emit || out_free) state_next = ST_IDLE;
      end
      ST_N_ABS: state_next = ST_N_SH;
      ST_N_SH: begin
        if (!big) state_next = ST_N_SQX;
      end
      ST_N_SQX: begin
        u_req.op = UOP_MULR;
        u_opa = {1'b0, ax};
        u_opb = {1'b0, ax};
        u_req.start = !issued;
        if (fire) state_next = ST_N_SQY;
      end
      ST_N_SQY: begin
        u_req.op = UOP_MULR;
        u_opa = {1'b0, ay};
        u_opb = {1'b0, ay};
        u_req.start = !issued;
        if (fire) state_next = ST_N_SQRT;
      end
      ST_N_SQRT: begin
        u_req.op = UOP_SQRT;
        u_req.start = !issued;
        if (fire) state_next = (u_root == '0) ? ret : ST_N_DX;
      end
      ST_N_DX: begin
        u_req.op = UOP_DIV;
        u_num = LW'(ax);
        u_den = (LW+1)'(r);
        u_req.start = !issued;
        if (fire) state_next = ST_N_DY;
      end
      ST_N_DY: begin
        u_req.op = UOP_DIV;
        u_num = LW'(ay);
        u_den = (LW+1)'(r);
        u_req.start = !issued;
        if (fire) state_next = ret;
      end
      default: state_next = ST_IDLE;
    endcase
    issued_next = u_req.start ? 1'b1 : (fire ? 1'b0 : issued);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= (W-1)'(MS_RESET_U);
      panic_dist <= CFG_DATA_BITS'(1310720);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAX_SPEED) begin
        max_speed <= (64'(cfg_data) > WMAX_U) ? (W-1)'(WMAX_U) : (W-1)'(cfg_data);
      end else if (cfg_index == CFG_PANIC_DIST) begin
        panic_dist <= cfg_data;
      end
    end
  end

  // running sum and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FIN && (!emit || out_free)) begin
        if (sum_mode) begin
          sum_x <= last ? '0 : sum_nx;
          sum_y <= last ? '0 : sum_ny;
        end
      end
      if (state == ST_FIN && emit && out_free) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && emit && out_free) begin
      out_x <= sum_mode ? to32(sum_nx) : to32(fx);
      out_y <= sum_mode ? to32(sum_ny) : to32(fy);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          op <= opcode_t'(s_axis_tuser[1:0]);
          sum_mode <= s_axis_tuser[2];
          last <= s_axis_tlast;
          spx <= field_in(s_axis_tdata[0*FIELD_BITS +: FIELD_BITS]);
          spy <= field_in(s_axis_tdata[1*FIELD_BITS +: FIELD_BITS]);
          svx <= field_in(s_axis_tdata[2*FIELD_BITS +: FIELD_BITS]);
          svy <= field_in(s_axis_tdata[3*FIELD_BITS +: FIELD_BITS]);
          tpx <= field_in(s_axis_tdata[4*FIELD_BITS +: FIELD_BITS]);
          tpy <= field_in(s_axis_tdata[5*FIELD_BITS +: FIELD_BITS]);
          tvx <= field_in(s_axis_tdata[6*FIELD_BITS +: FIELD_BITS]);
          tvy <= field_in(s_axis_tdata[7*FIELD_BITS +: FIELD_BITS]);
        end
      end
      ST_DISPATCH: begin
        if (op == OP_PURSUE) begin
          nvx <= wx1(svx);
          nvy <= wx1(svy);
          ret <= ST_P_HEAD;
        end else begin
          px <= tpx;
          py <= tpy;
        end
      end
      ST_P_HEAD: begin
        hx <= nux;
        hy <= nuy;
        nvx <= wx1(tvx);
        nvy <= wx1(tvy);
        ret <= ST_P_M1;
      end
      ST_P_M1: if (fire) m1 <= u_mul_q;
      ST_P_M2: if (fire) m2 <= u_mul_q;
      ST_P_M3: if (fire) m3 <= u_mul_q;
      ST_P_M4: if (fire) m4 <= u_mul_q;
      ST_P_DEC: begin
        if (head_on) begin
          px <= tpx;
          py <= tpy;
        end
      end
      ST_PR_D: begin
        nvx <= dx;
        nvy <= dy;
        ret <= ST_PR_T;
      end
      ST_PR_T: begin
        tgt_dist <= nlen;
        nvx <= wx1(tvx);
        nvy <= wx1(tvy);
        ret <= ST_PR_DIV;
      end
      ST_PR_DIV: begin
        if (den == '0) t <= '0;
        else if (fire) t <= u_quo;
      end
      ST_PR_MX: if (fire) px <= satw(xs(wx1(tpx) + wx1(u_mul_q)));
      ST_PR_MY: if (fire) py <= satw(xs(wx1(tpy) + wx1(u_mul_q)));
      ST_SEEK: begin
        nvx <= wx1(px) - wx1(spx);
        nvy <= wx1(py) - wx1(spy);
        ret <= ST_FX;
      end
      ST_FLEE: begin
        nvx <= wx1(spx) - wx1(px);
        nvy <= wx1(spy) - wx1(py);
        ret <= ST_F_CHK;
      end
      ST_F_CHK: begin
        if (outside) begin
          fx <= '0;
          fy <= '0;
        end
      end
      ST_FX: if (fire) fx <= satw(xs(wx1(u_mul_q) - wx1(svx)));
      ST_FY: if (fire) fy <= satw(xs(wx1(u_mul_q) - wx1(svy)));
      // vector normalization
      ST_N_ABS: begin
        ax <= nvx[W] ? unsigned'(-nvx) : unsigned'(nvx);
        ay <= nvy[W] ? unsigned'(-nvy) : unsigned'(nvy);
        sgx <= nvx[W];
        sgy <= nvy[W];
        sh <= '0;
      end
      ST_N_SH: begin
        if (big) begin
          ax <= ax >> 1;
          ay <= ay >> 1;
          sh <= sh + SHW'(1);
        end
      end
      ST_N_SQX: if (fire) sq <= 64'(u_mul_raw);
      ST_N_SQY: if (fire) sq <= sq + 64'(u_mul_raw);
      ST_N_SQRT: begin
        if (fire) begin
          r <= u_root;
          if (u_root == '0) begin
            nux <= '0;
            nuy <= '0;
            nlen <= '0;
          end
        end
      end
      ST_N_DX: if (fire) nux <= sgx ? -qs : qs;
      ST_N_DY: begin
        if (fire) begin
          nuy <= sgy ? -qs : qs;
          nlen <= LW'(64'(r) << sh);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/pes_unit.sv =====
module pes_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pes_pkg::unit_req_t             req,
  input  logic signed [WORD_BITS+1:0]    opa,
  input  logic signed [WORD_BITS+1:0]    opb,
  input  logic [63:0]                    rad,
  input  logic [WORD_BITS+1:0]           num,
  input  logic [WORD_BITS+2:0]           den,
  output logic                           done,
  output logic signed [WORD_BITS-1:0]    mul_q,
  output logic [2*WORD_BITS+1:0]         mul_raw,
  output logic [31:0]                    root,
  output logic [WORD_BITS-2:0]           quo
);
  import pes_pkg::*;

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int MW = W + 1;
  localparam int PW = 2 * MW;
  localparam int LW = W + 2;
  localparam int QW = LW + F;
  localparam int STEPS = (QW > MW) ? ((QW > 32) ? QW : 32) : ((MW > 32) ? MW : 32);
  localparam int CW = $clog2(STEPS + 1);
  localparam logic [PW-1:0] CAP_POS = (PW'(1) << (W - 1)) - PW'(1);
  localparam logic [PW-1:0] CAP_NEG = PW'(1) << (W - 1);
  localparam logic [63:0] WMAX_U = (64'd1 << (W - 1)) - 64'd1;
  localparam logic [LW-1:0] QINT_CAP = LW'(WMAX_U >> F);

  logic          busy;
  logic [CW-1:0] cnt;
  unit_op_t      op_r;

  // multiplier: shift-add, one bit of the multiplier per cycle
  logic [MW-1:0] mag_a;
  logic [MW-1:0] acc_hi;
  logic [MW-1:0] acc_lo;
  logic          neg;
  logic [MW:0]   msum;
  logic [PW-1:0] prod;
  logic [PW-1:0] pshift;
  logic [PW-1:0] pcap;
  logic [PW-1:0] pclip;

  // square root: one root bit per cycle
  logic [63:0] s_x;
  logic [63:0] s_r;
  logic [63:0] s_bit;
  logic [63:0] s_try;
  logic        s_ge;

  // restoring divider: integer bits then fraction bits
  logic [LW:0]   d_rem;
  logic [LW:0]   d_den;
  logic [LW-1:0] d_num;
  logic [QW-1:0] d_q;
  logic          d_nb;
  logic [LW+1:0] d_sh;
  logic [LW+1:0] d_sub;
  logic          d_ge;

  assign msum = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, mag_a} : '0);
  assign prod = {acc_hi, acc_lo};
  assign pshift = prod >> F;
  assign pcap = neg ? CAP_NEG : CAP_POS;
  assign pclip = (pshift > pcap) ? pcap : pshift;
  assign mul_q = neg ? -W'(pclip) : W'(pclip);
  assign mul_raw = prod;

  assign s_try = s_r + s_bit;
  assign s_ge = s_x >= s_try;
  assign root = s_r[31:0];

  assign d_nb = (cnt > CW'(F)) ? d_num[LW-1] : 1'b0;
  assign d_sh = {d_rem, d_nb};
  assign d_sub = d_sh - {1'b0, d_den};
  assign d_ge = d_sh >= {1'b0, d_den};
  assign quo = (d_q[QW-1:F] > QINT_CAP) ? (W-1)'(WMAX_U) : d_q[W-2:0];

  // step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        case (req.op)
          UOP_MULQ, UOP_MULR: cnt <= CW'(MW);
          UOP_SQRT:           cnt <= CW'(32);
          UOP_DIV:            cnt <= CW'(QW);
          default:            cnt <= CW'(MW);
        endcase
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      case (req.op)
        UOP_MULQ, UOP_MULR: begin
          mag_a <= opa[W+1] ? MW'(-opa) : MW'(opa);
          acc_lo <= opb[W+1] ? MW'(-opb) : MW'(opb);
          acc_hi <= '0;
          neg <= opa[W+1] ^ opb[W+1];
        end
        UOP_SQRT: begin
          s_x <= rad;
          s_r <= '0;
          s_bit <= 64'd1 << 62;
        end
        default: begin
          d_rem <= '0;
          d_num <= num;
          d_den <= den;
          d_q <= '0;
        end
      endcase
    end else if (busy) begin
      case (op_r)
        UOP_MULQ, UOP_MULR: begin
          acc_hi <= msum[MW:1];
          acc_lo <= {msum[0], acc_lo[MW-1:1]};
        end
        UOP_SQRT: begin
          if (s_ge) begin
            s_x <= s_x - s_try;
            s_r <= (s_r >> 1) + s_bit;
          end else begin
            s_r <= s_r >> 1;
          end
          s_bit <= s_bit >> 2;
        end
        default: begin
          d_num <= d_num << 1;
          if (d_ge) begin
            d_rem <= d_sub[LW:0];
            d_q <= {d_q[QW-2:0], 1'b1};
          end else begin
            d_rem <= d_sh[LW:0];
            d_q <= {d_q[QW-2:0], 1'b0};
          end
        end
      endcase
    end
  end

endmodule

// ===== tb/steering_checker.sv =====
`default_nettype none

module steering_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [255:0] s_axis_tdata,
  input  wire logic [2:0]   s_axis_tuser,
  input  wire logic         s_axis_tlast,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [63:0]  m_axis_tdata,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [30:0]  cfg_data,
  output int                errors,
  output int                pending,
  output int                forces_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import pes_pkg::*;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam longint HEAD_THR = (64'sd95 << 16) / 100;

  // configuration and running sum copies
  longint unsigned speed_q, panic_q;
  longint acc_x, acc_y;
  logic [63:0] force_q[$];

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint clamp(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint unsigned umul_shift(longint unsigned a, longint unsigned b,
                                                 longint unsigned cap);
    logic [127:0] p;
    longint unsigned r;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:80] != 0) return cap;
    r = p[79:16];
    return r > cap ? cap : r;
  endfunction

  function automatic longint qmul(longint a, longint b);
    bit neg;
    longint unsigned m;
    neg = (a < 0) != (b < 0);
    m = umul_shift(mag(a), mag(b), neg ? 64'd2147483648 : 64'd2147483647);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  // unit vector, returns the length
  function automatic longint unsigned unit_dir(longint dx, longint dy,
                                               output longint ux, output longint uy);
    longint unsigned ax, ay, r;
    int sh;
    ax = mag(dx);
    ay = mag(dy);
    sh = 0;
    while ((ax | ay) >= (64'd1 << 30)) begin
      ax >>= 1;
      ay >>= 1;
      sh++;
    end
    r = int_sqrt(ax * ax + ay * ay);
    ux = 0;
    uy = 0;
    if (r == 0) return 0;
    ux = longint'((ax << 16) / r);
    uy = longint'((ay << 16) / r);
    if (dx < 0) ux = -ux;
    if (dy < 0) uy = -uy;
    return r << sh;
  endfunction

  function automatic longint unsigned div_q(longint unsigned num, longint unsigned den,
                                            longint unsigned cap);
    longint unsigned q, rem, res;
    q = num / den;
    rem = num % den;
    if (q > (cap >> 16)) return cap;
    res = q;
    for (int i = 0; i < 16; i++) begin
      rem <<= 1;
      res <<= 1;
      if (rem >= den) begin
        rem -= den;
        res |= 1;
      end
    end
    return res > cap ? cap : res;
  endfunction

  function automatic void steer_to(longint svx, longint svy, longint dx, longint dy,
                                   output longint fx, output longint fy);
    longint ux, uy;
    longint unsigned l;
    l = unit_dir(dx, dy, ux, uy);
    fx = clamp(qmul(ux, longint'(speed_q)) - svx);
    fy = clamp(qmul(uy, longint'(speed_q)) - svy);
  endfunction

  // zero force outside the panic radius
  function automatic void flee_away(longint svx, longint svy, longint dx, longint dy,
                                    output longint fx, output longint fy);
    longint ux, uy;
    fx = 0;
    fy = 0;
    if (unit_dir(dx, dy, ux, uy) < panic_q) steer_to(svx, svy, dx, dy, fx, fy);
  endfunction

  function automatic void lead_point(longint v[8], output longint px, output longint py);
    longint ux, uy, t;
    longint unsigned tgt_dist, tvl, den;
    tgt_dist = unit_dir(v[4] - v[0], v[5] - v[1], ux, uy);
    tvl = unit_dir(v[6], v[7], ux, uy);
    den = speed_q + tvl;
    t = den != 0 ? longint'(div_q(tgt_dist, den, 64'd2147483647)) : 0;
    px = clamp(v[4] + qmul(t, v[6]));
    py = clamp(v[5] + qmul(t, v[7]));
  endfunction

  function automatic void steering_force(opcode_t op, logic [255:0] d,
                                         output longint fx, output longint fy);
    longint v[8];
    longint px, py, hx, hy, ex, ey;
    longint unsigned l;
    for (int i = 0; i < 8; i++) v[i] = longint'($signed(d[32*i +: 32]));
    case (op)
      OP_SEEK: steer_to(v[2], v[3], v[4] - v[0], v[5] - v[1], fx, fy);
      OP_FLEE: flee_away(v[2], v[3], v[0] - v[4], v[1] - v[5], fx, fy);
      OP_PURSUE: begin
        l = unit_dir(v[2], v[3], hx, hy);
        l = unit_dir(v[6], v[7], ex, ey);
        if (qmul(v[4] - v[0], hx) + qmul(v[5] - v[1], hy) > 0 &&
            qmul(hx, ex) + qmul(hy, ey) < -HEAD_THR) begin
          steer_to(v[2], v[3], v[4] - v[0], v[5] - v[1], fx, fy);
        end else begin
          lead_point(v, px, py);
          steer_to(v[2], v[3], px - v[0], py - v[1], fx, fy);
        end
      end
      default: begin
        lead_point(v, px, py);
        flee_away(v[2], v[3], v[0] - px, v[1] - py, fx, fy);
      end
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s at %0t: got %h expected %h", what, $realtime, got, want);
    errors++;
  endtask

  assign pending = force_q.size();

  // predict on input and config transactions, compare on output transactions
  always @(posedge clk) begin
    longint fx, fy;
    logic [63:0] want;
    if (rst) begin
      speed_q <= 65536;
      panic_q <= 1310720;
      acc_x <= 0;
      acc_y <= 0;
      errors <= 0;
      forces_seen <= 0;
      force_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_SPEED) speed_q <= cfg_data;
        else if (cfg_index == CFG_PANIC_DIST) panic_q <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        steering_force(opcode_t'(s_axis_tuser[1:0]), s_axis_tdata, fx, fy);
        if (s_axis_tuser[2]) begin
          fx = clamp(acc_x + fx);
          fy = clamp(acc_y + fy);
          if (s_axis_tlast) begin
            acc_x <= 0;
            acc_y <= 0;
            force_q.push_back({fy[31:0], fx[31:0]});
          end else begin
            acc_x <= fx;
            acc_y <= fy;
          end
        end else begin
          force_q.push_back({fy[31:0], fx[31:0]});
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        forces_seen <= forces_seen + 1;
        if (force_q.size() == 0) begin
          report("unexpected force", m_axis_tdata[31:0], 32'h0);
        end else begin
          want = force_q.pop_front();
          if (m_axis_tdata[31:0] != want[31:0])
            report("force_x", m_axis_tdata[31:0], want[31:0]);
          if (m_axis_tdata[63:32] != want[63:32])
            report("force_y", m_axis_tdata[63:32], want[63:32]);
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pes_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready, s_axis_tlast = 0;
  logic [255:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic cfg_valid = 0, cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  int errors, pending, forces_seen;
  int items_sent = 0, burst_left = 0;
  logic [7:0][31:0] f;

  always #5 clk = ~clk;

  pursuit_evasion_steering u_top (.*);

  steering_checker u_chk (.*);

  task automatic cfg_write(logic [7:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // let the block drain, including a trailing sum item with no result
  task automatic drain();
    @(negedge clk);
    while (s_axis_tvalid || pending != 0) @(negedge clk);
    repeat (1600) @(negedge clk);
  endtask

  task automatic send_item(opcode_t op, logic [7:0][31:0] d, logic sum, logic lst);
    int gap;
    @(negedge clk);
    s_axis_tvalid = 1;
    s_axis_tdata = d;
    s_axis_tuser = {sum, op};
    s_axis_tlast = lst;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    // bursts with random gaps
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 400);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid = 0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic idle_sender();
    @(negedge clk);
    s_axis_tvalid = 0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return $urandom_range(0, 32'd13107200) - 32'd6553600;
    endcase
  endfunction

  // receiver stall pattern with one long hold-off
  initial begin
    int mode;
    @(negedge clk);
    while (rst) @(negedge clk);
    for (int n = 0; ; n++) begin
      if (n == 60) begin
        m_axis_tready = 0;
        repeat (6000) @(negedge clk);
      end
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(50, 600)) begin
        @(negedge clk);
        m_axis_tready = mode == 0 ? 1'b1 :
                        mode == 1 ? 1'($urandom_range(0, 1)) :
                                    ($urandom_range(0, 7) == 0);
      end
    end
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic sum, lst;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: every opcode at default settings
    f = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    send_item(OP_SEEK, f, 0, 0);              // zero vectors everywhere
    send_item(OP_PURSUE, f, 0, 0);
    // index order high to low: tvy tvx tpy tpx svy svx spy spx
    f = '{32'h0, 32'hffff_0000, 32'h0, 32'h000a_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0};
    send_item(OP_PURSUE, f, 0, 0);            // head-on target ahead
    send_item(OP_EVADE, f, 0, 0);
    send_item(OP_FLEE, f, 0, 1);              // last without sum mode
    f = '{32'h0, 32'h0, 32'h0, 32'h0064_0000, 32'h0, 32'h0, 32'h0, 32'h0};
    send_item(OP_FLEE, f, 0, 0);              // outside panic radius
    f = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
          32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
    for (int op = 0; op < 4; op++) send_item(opcode_t'(op), f, 0, 0);
    f = ~f;
    for (int op = 0; op < 4; op++) send_item(opcode_t'(op), f, 1, op == 3);
    f = '{32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0};
    send_item(OP_SEEK, f, 1, 0);
    send_item(OP_FLEE, f, 1, 1);
    idle_sender();
    drain();

    // sweep settings, extremes included
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: cfg_write(CFG_MAX_SPEED, 31'd0);
        1: cfg_write(CFG_MAX_SPEED, 31'h7fff_ffff);
        2: cfg_write(CFG_PANIC_DIST, 31'd0);
        3: cfg_write(CFG_PANIC_DIST, 31'h7fff_ffff);
        4: cfg_write(8'd2, $urandom);           // ignored index
        default: begin
          cfg_write(CFG_MAX_SPEED, $urandom_range(0, 31'h0008_0000));
          cfg_write(CFG_PANIC_DIST, $urandom_range(0, 31'h0200_0000));
        end
      endcase
      if (phase == 0) begin
        // zero lookahead divisor
        f = '{32'h0, 32'h0, 32'h0, 32'h0005_0000, 32'h0, 32'h0, 32'h0, 32'h0};
        send_item(OP_PURSUE, f, 0, 0);
        send_item(OP_EVADE, f, 0, 0);
      end
      repeat (phase < 4 ? 30 : 110) begin
        for (int i = 0; i < 8; i++) f[i] = pick_value();
        sum = $urandom_range(0, 2) == 0;
        lst = $urandom_range(0, 3) == 0;
        send_item(opcode_t'($urandom_range(0, 3)), f, sum, lst);
      end
      idle_sender();
      drain();
    end

    $display("Sent %0d steering items over 8 setting phases, checked %0d forces",
             items_sent, forces_seen);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
